FILE: rtl/core/gaussian_fitness_product_core_assert.svh
// assertion helpers for the fitness product core
`ifndef GAUSSIAN_FITNESS_PRODUCT_CORE_ASSERT_SVH
`define GAUSSIAN_FITNESS_PRODUCT_CORE_ASSERT_SVH
`ifndef SYNTH
`define GFP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fitness core check failed");
`define GFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fitness core sequence check failed");
`else
`define GFP_ASSERT_IMP(lbl, ante, cons)
`define GFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/core/gfp_pkg.sv
package gfp_pkg;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [31:0] Q31_ONE = 32'h8000_0000;
  // floor(x/6) == (x * DIV6_MUL) >> 20 for x < 2^19
  localparam logic [17:0] DIV6_MUL = 18'd174763;

  localparam logic [1:0] REG_STRENGTH = 2'd0;
  localparam logic [1:0] REG_INV_SIGMA = 2'd1;

  localparam logic [3:0] LSTEP_IDLE  = 4'd0;
  localparam logic [3:0] LSTEP_TAB0  = 4'd7;
  localparam logic [3:0] LSTEP_LAST  = 4'd14;

  typedef struct packed {
    logic        done;
    logic [30:0] g;
  } gauss_res_t;

  // exp(-2^i/16), Q0.30
  function automatic logic [31:0] exp_tab(input logic [2:0] i);
    logic [31:0] v;
    case (i)
      3'd0: v = 32'd1008687093;
      3'd1: v = 32'd947573834;
      3'd2: v = 32'd836230973;
      3'd3: v = 32'd651257337;
      3'd4: v = 32'd395007542;
      3'd5: v = 32'd145315154;
      3'd6: v = 32'd19666267;
      3'd7: v = 32'd360200;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/gfp_gauss_lane.sv
module gfp_gauss_lane import gfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] allele,
  input  logic [16:0] optimum,
  input  logic [23:0] inv_sigma,
  output gauss_res_t  res
);

  logic [3:0]  step;
  logic [16:0] mag;
  logic [64:0] p;
  logic [7:0]  m;
  logic [25:0] r;
  logic [21:0] r2;
  logic [30:0] g;
  logic        zero;

  logic [33:0] opa;
  logic [31:0] opb;
  logic [64:0] p_c;
  logic [2:0]  idx;
  logic [25:0] r_c;
  logic [21:0] r2_c;
  logic [17:0] r3_c;
  logic [17:0] div_c;

  assign idx   = 3'(step - LSTEP_TAB0);
  assign r_c   = p[43:18];
  assign r2_c  = p[51:30];
  assign r3_c  = p[47:30];
  assign div_c = p[37:20];

  // one shared multiplier, operands chosen by step
  always_comb begin
    opa = '0;
    opb = '0;
    case (step)
      4'd1: begin opa = {17'd0, mag}; opb = {15'd0, mag}; end
      4'd2: begin opa = p[33:0]; opb = {8'd0, inv_sigma}; end
      4'd3: begin opa = {8'd0, r_c}; opb = {6'd0, r_c}; end
      4'd4: begin opa = {12'd0, r2_c}; opb = {6'd0, r}; end
      4'd5: begin opa = {16'd0, r3_c}; opb = {14'd0, DIV6_MUL}; end
      default: begin opa = {3'd0, g}; opb = exp_tab(idx); end
    endcase
  end

  assign p_c = 65'(opa) * 65'(opb);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= LSTEP_IDLE;
    end else if (step == LSTEP_IDLE) begin
      if (start) step <= 4'd1;
    end else if (step == LSTEP_LAST) begin
      step <= LSTEP_IDLE;
    end else begin
      step <= step + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    p <= p_c;
    case (step)
      LSTEP_IDLE: begin
        mag  <= (allele >= optimum) ? (allele - optimum) : (optimum - allele);
        zero <= 1'b0;
      end
      4'd3: begin
        zero <= (p[64:52] != '0);
        m    <= p[51:44];
        r    <= r_c;
      end
      4'd4: r2 <= r2_c;
      4'd6: g <= Q30_ONE - {5'd0, r} + {10'd0, r2[21:1]} - {13'd0, div_c};
      default: begin
        if (step >= LSTEP_TAB0 && m[idx]) g <= p_c[60:30];
      end
    endcase
  end

  assign res.done = (step == LSTEP_LAST);
  assign res.g    = zero ? '0 : (m[7] ? p_c[60:30] : g);

endmodule

FILE: rtl/core/gfp_merge.sv
module gfp_merge import gfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  gauss_res_t  res_a,
  input  gauss_res_t  res_b,
  input  logic [31:0] sw30,
  input  logic        last,
  output logic        finish,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] fitness
);

  logic [2:0]  step;
  logic [30:0] g_a;
  logic [30:0] g_b;
  logic [31:0] prod;
  logic [62:0] p;
  logic [31:0] opa;
  logic [30:0] opb;
  logic [32:0] s;
  logic [30:0] factor;
  logic        can_out;

  assign s       = p[62:30];
  assign factor  = (s >= {2'd0, Q30_ONE}) ? '0 : 31'(33'(Q30_ONE) - s);
  assign can_out = !out_valid || out_ready;
  assign finish  = (step == 3'd5) && (!last || can_out);

  always_comb begin
    case (step)
      3'd1: begin opa = sw30; opb = g_a; end
      3'd3: begin opa = sw30; opb = g_b; end
      default: begin opa = prod; opb = factor; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
      prod      <= Q31_ONE;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (step)
        3'd0: if (res_a.done) step <= 3'd1;
        3'd3: begin prod <= p[61:30]; step <= 3'd4; end
        3'd5: begin
          if (finish) begin
            step <= '0;
            if (last) begin
              prod      <= Q31_ONE;
              out_valid <= 1'b1;
            end else begin
              prod <= p[61:30];
            end
          end
        end
        default: step <= step + 3'd1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step == 3'd0 && res_a.done) begin
      g_a <= res_a.g;
      g_b <= res_b.g;
    end
    if (step != 3'd5) p <= 63'(opa) * 63'(opb);
    if (finish && last) fitness <= p[61:30];
  end

endmodule

FILE: rtl/core/gaussian_fitness_product_core.sv
// Fitness goes out on the last locus; a new locus is accepted only once the
// previous one has finished merging. The gaussian lanes run 14 steps on a
// shared multiplier each, then the merge stage folds two factors in 5 steps.
// Reset: strength 0, inverse sigma 1.0, running product 1.0, nothing pending.
`include "gaussian_fitness_product_core_assert.svh"
module gaussian_fitness_product_core import gfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [16:0] allele_first,
  input  logic [16:0] allele_second,
  input  logic [16:0] env_optimum,
  input  logic [16:0] loc_weight,
  input  logic        last_locus,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] fitness,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  logic [16:0] strength;
  logic [23:0] inverse_sigma;
  logic        busy;
  logic [31:0] sw30;
  logic        last;
  logic        accept;
  logic        finish;
  gauss_res_t  res_a;
  gauss_res_t  res_b;
  logic [33:0] sw_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign sw_full   = 34'(strength) * 34'(loc_weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      strength      <= '0;
      inverse_sigma <= 24'd65536;
      busy          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_STRENGTH:  strength      <= cfg_data[16:0];
          REG_INV_SIGMA: inverse_sigma <= cfg_data;
          default: ;
        endcase
      end
      if (accept) busy <= 1'b1;
      else if (finish) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sw30 <= sw_full[33:2];
      last <= last_locus;
    end
  end

  gfp_gauss_lane u_lane_a (
    .clk(clk), .rst(rst), .start(accept), .allele(allele_first),
    .optimum(env_optimum), .inv_sigma(inverse_sigma), .res(res_a)
  );

  gfp_gauss_lane u_lane_b (
    .clk(clk), .rst(rst), .start(accept), .allele(allele_second),
    .optimum(env_optimum), .inv_sigma(inverse_sigma), .res(res_b)
  );

  gfp_merge u_merge (
    .clk(clk), .rst(rst), .res_a(res_a), .res_b(res_b), .sw30(sw30),
    .last(last), .finish(finish), .out_valid(out_valid),
    .out_ready(out_ready), .fitness(fitness)
  );

  `GFP_ASSERT_NEXT(a_busy_after_req, accept, !in_ready)
  `GFP_ASSERT_IMP(a_fit_range, out_valid, fitness <= Q31_ONE)
  `GFP_ASSERT_IMP(a_lanes_paired, res_a.done, res_b.done && busy)

endmodule

FILE: sim/tb_top.sv
module tb_top;
  import gfp_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [16:0] allele_first = '0;
  logic [16:0] allele_second = '0;
  logic [16:0] env_optimum = '0;
  logic [16:0] loc_weight = '0;
  logic        last_locus = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] fitness;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  gaussian_fitness_product_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [16:0] a0;
    logic [16:0] a1;
    logic [16:0] theta;
    logic [16:0] weight;
    logic        last;
  } locus_t;

  localparam logic [63:0] FRAC28 = (64'd1 << 28) - 1;
  localparam logic [63:0] ONE30 = 64'd1 << 30;

  locus_t      locus_q[$];
  logic [31:0] fitness_q[$];
  logic [16:0] strength_m = '0;
  logic [23:0] inv_sigma_m = 24'd65536;
  logic [31:0] product_m = Q31_ONE;
  int          errors = 0;
  int          cycles = 0;
  bit          hold_off = 1'b0;
  bit          stim_done = 1'b0;

  // exp(-2^i/16), Q0.30
  function automatic logic [63:0] exp_step(input int i);
    logic [63:0] t [8];
    t = '{64'd1008687093, 64'd947573834, 64'd836230973, 64'd651257337,
          64'd395007542, 64'd145315154, 64'd19666267, 64'd360200};
    return t[i];
  endfunction

  function automatic logic [63:0] gauss(input logic [16:0] x, input logic [16:0] th);
    logic [63:0] d, a, r, r2, r3, g;
    logic [7:0]  m;
    d = (x >= th) ? 64'(x - th) : 64'(th - x);
    a = ((d * d) * 64'(inv_sigma_m)) >> 16;
    if (a >= (64'd16 << 32)) return 64'd0;
    m = a[35:28];
    r = (a & FRAC28) >> 2;
    r2 = (r * r) >> 30;
    r3 = (r2 * r) >> 30;
    g = ONE30 - r + (r2 >> 1) - r3 / 6;
    for (int i = 0; i < 8; i++)
      if (m[i]) g = (g * exp_step(i)) >> 30;
    return g;
  endfunction

  function automatic void fold_allele(input logic [16:0] x, input logic [16:0] th,
                                      input logic [63:0] sw);
    logic [63:0] s, f;
    s = (sw * gauss(x, th)) >> 30;
    f = (s >= ONE30) ? 64'd0 : ONE30 - s;
    product_m = 32'((64'(product_m) * f) >> 30);
  endfunction

  // predicts and queues the request
  task automatic push_locus(input locus_t l);
    logic [63:0] sw;
    sw = (64'(strength_m) * 64'(l.weight)) >> 2;
    fold_allele(l.a0, l.theta, sw);
    fold_allele(l.a1, l.theta, sw);
    if (l.last) begin
      fitness_q.insert(fitness_q.size(), product_m);
      product_m = Q31_ONE;
    end
    locus_q.insert(locus_q.size(), l);
  endtask

  function automatic logic [16:0] rnd17();
    case ($urandom_range(0, 5))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // theta near allele so the gaussian is not always zero
  function automatic locus_t rnd_locus(input int plen);
    locus_t l;
    l.theta = rnd17();
    l.a0 = ($urandom_range(0, 3) == 0) ? rnd17()
         : 17'(l.theta + $urandom_range(0, 2047) - 1024);
    l.a1 = ($urandom_range(0, 3) == 0) ? rnd17()
         : 17'(l.theta + $urandom_range(0, 2047) - 1024);
    l.weight = rnd17();
    l.last = ($urandom_range(1, plen) == 1);
    return l;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_STRENGTH) strength_m = val[16:0];
    else if (idx == REG_INV_SIGMA) inv_sigma_m = val;
  endtask

  task automatic drain();
    while (locus_q.size() != 0 || fitness_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) void'(locus_q.pop_front());
      if (in_valid && !in_ready) begin
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (locus_q.size() > 0) begin
        locus_t l;
        l = locus_q[0];
        in_valid <= 1'b1;
        allele_first <= l.a0;
        allele_second <= l.a1;
        env_optimum <= l.theta;
        loc_weight <= l.weight;
        last_locus <= l.last;
        in_gap <= ($urandom_range(0, 9) < 6) ? 0
                : ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (fitness_q.size() == 0) begin
          $display("%0t: unexpected fitness %0d", $time, fitness);
          errors <= errors + 1;
        end else begin
          if (fitness !== fitness_q[0]) begin
            $display("%0t: fitness expected %0d actual %0d", $time, fitness_q[0], fitness);
            errors <= errors + 1;
          end
          void'(fitness_q.pop_front());
        end
      end
      if (hold_off) out_ready <= 1'b0;
      else if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) >= 7)
          out_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // strength 0 at reset: product stays 1.0
    push_locus('{17'd100, 17'd65536, 17'd0, 17'd65536, 1'b1});
    drain();
    write_reg(REG_STRENGTH, 24'd65536);
    write_reg(REG_INV_SIGMA, 24'd65536);
    push_locus('{17'd0, 17'd0, 17'd0, 17'd65536, 1'b1});        // full selection, zero
    push_locus('{17'd0, 17'd65536, 17'd65536, 17'd0, 1'b1});    // zero weight
    push_locus('{17'd65536, 17'd0, 17'd0, 17'd32768, 1'b0});
    push_locus('{17'd1000, 17'd2000, 17'd1500, 17'd65536, 1'b0});
    push_locus('{17'h1FFFF, 17'h1FFFF, 17'd0, 17'h1FFFF, 1'b1}); // beyond range
    push_locus('{17'd30000, 17'd30100, 17'd30050, 17'd40000, 1'b1});
    drain();
    write_reg(REG_INV_SIGMA, 24'd0);                            // g = 1
    write_reg(2'd2, 24'hABCDEF);                                // ignored index
    write_reg(2'd3, 24'h123456);
    push_locus('{17'd5, 17'd60000, 17'd7, 17'd20000, 1'b0});
    push_locus('{17'd9, 17'd9, 17'd9, 17'd1, 1'b1});
    drain();
    write_reg(REG_INV_SIGMA, 24'hFFFFFF);
    write_reg(REG_STRENGTH, 24'hFFFFFF);
    push_locus('{17'd0, 17'd65536, 17'd0, 17'd65536, 1'b1});
    push_locus('{17'd300, 17'd301, 17'd300, 17'd65536, 1'b1});
    drain();

    // stall the receiver while requests keep coming
    write_reg(REG_STRENGTH, 24'd20000);
    write_reg(REG_INV_SIGMA, 24'd4000);
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) push_locus(rnd_locus(2));
    repeat (600) @(posedge clk);
    hold_off = 1'b0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_STRENGTH, (ph == 0) ? 24'd0 : (ph == 1) ? 24'h1FFFF
                : 24'($urandom_range(0, 65536)));
      write_reg(REG_INV_SIGMA, (ph == 2) ? 24'd1 : (ph == 3) ? 24'hFFFFFF
                : (ph == 4) ? 24'($urandom) : 24'($urandom_range(1, 1 << 20)));
      for (int i = 0; i < 160; i++) push_locus(rnd_locus(1 + ph % 6));
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    wait (cycles >= 2000000);
    $display("Verification failed");
    $finish;
  end
endmodule
